// ----- sv/sfir_pkg.sv -----
// sfir_pkg: constants, configuration struct and helper functions
// shared by the separable 2-d fir filter modules; no dependencies
package sfir_pkg;

  localparam int MAX_TAPS   = 8;
  localparam int TAP_W      = 3;
  localparam int CNT_W      = 4;
  localparam int COEF_W     = 16;
  localparam int FRAC_BITS  = 14;
  localparam int ROUND_ADD  = 1 << (FRAC_BITS - 1);
  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 6;
  localparam int OWR_W      = 11;

  typedef enum logic [2:0] {
    REG_TAP_X  = 3'd0,
    REG_TAP_Y  = 3'd1,
    REG_ROW_LO = 3'd2,
    REG_ROW_HI = 3'd3,
    REG_COL_LO = 3'd4,
    REG_COL_HI = 3'd5,
    REG_OUT_W  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0]  tap_count_x;
    logic [CNT_W-1:0]  tap_count_y;
    logic [DATA_W-1:0] row_taps_low;
    logic [DATA_W-1:0] row_taps_high;
    logic [DATA_W-1:0] col_taps_low;
    logic [DATA_W-1:0] col_taps_high;
    logic [OWR_W-1:0]  out_width;
  } cfg_t;

  function automatic logic [CNT_W-1:0] clamp_taps(input logic [CNT_W-1:0] t);
    logic [CNT_W-1:0] r;
    r = t;
    if (t == '0) r = CNT_W'(1);
    else if (t > CNT_W'(MAX_TAPS)) r = CNT_W'(MAX_TAPS);
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_sel(input logic [DATA_W-1:0] lo,
                                                         input logic [DATA_W-1:0] hi,
                                                         input logic [TAP_W-1:0] k);
    logic [DATA_W-1:0] w;
    w = k[2] ? hi : lo;
    return w[k[1:0]*COEF_W +: COEF_W];
  endfunction

endpackage

// ----- sv/sfir_pixel_if.sv -----
// sfir_pixel_if: valid/ready channel carrying one source pixel word
// depends on nothing
interface sfir_pixel_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] pixel;
  logic                          frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink (input valid, pixel, frame_start, output ready);
endinterface

// ----- sv/sfir_result_if.sv -----
// sfir_result_if: valid/ready channel carrying one filtered result word
// depends on nothing
interface sfir_result_if #(parameter int SAMPLE_BITS = 16);
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_BITS+7:0]   value;
  logic                            last_in_row;
  logic                            saturated;
  modport source (output valid, value, last_in_row, saturated, input ready);
  modport sink (input valid, value, last_in_row, saturated, output ready);
endinterface

// ----- sv/sfir_apb_regs.sv -----
// sfir_apb_regs: apb configuration register file
// depends on sfir_pkg
module sfir_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfir_pkg::ADDR_W-1:0] paddr,
  input  logic [sfir_pkg::DATA_W-1:0] pwdata,
  output logic [sfir_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output sfir_pkg::cfg_t              cfg_o
);
  import sfir_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_count_x   <= CNT_W'(1);
      cfg_q.tap_count_y   <= CNT_W'(1);
      cfg_q.row_taps_low  <= DATA_W'(ROUND_ADD << 1);
      cfg_q.row_taps_high <= '0;
      cfg_q.col_taps_low  <= DATA_W'(ROUND_ADD << 1);
      cfg_q.col_taps_high <= '0;
      cfg_q.out_width     <= OWR_W'(1024);
    end else if (wr_en) begin
      case (idx)
        REG_TAP_X:  cfg_q.tap_count_x   <= pwdata[CNT_W-1:0];
        REG_TAP_Y:  cfg_q.tap_count_y   <= pwdata[CNT_W-1:0];
        REG_ROW_LO: cfg_q.row_taps_low  <= pwdata;
        REG_ROW_HI: cfg_q.row_taps_high <= pwdata;
        REG_COL_LO: cfg_q.col_taps_low  <= pwdata;
        REG_COL_HI: cfg_q.col_taps_high <= pwdata;
        REG_OUT_W:  cfg_q.out_width     <= pwdata[OWR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TAP_X:  prdata = DATA_W'(cfg_q.tap_count_x);
      REG_TAP_Y:  prdata = DATA_W'(cfg_q.tap_count_y);
      REG_ROW_LO: prdata = cfg_q.row_taps_low;
      REG_ROW_HI: prdata = cfg_q.row_taps_high;
      REG_COL_LO: prdata = cfg_q.col_taps_low;
      REG_COL_HI: prdata = cfg_q.col_taps_high;
      REG_OUT_W:  prdata = DATA_W'(cfg_q.out_width);
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- sv/sfir_round_sat.sv -----
// sfir_round_sat: round half up, drop fraction bits, saturate with clip flag
// depends on sfir_pkg
module sfir_round_sat #(
  parameter int IN_W  = 35,
  parameter int OUT_W = 20
) (
  input  logic signed [IN_W-1:0]  acc_i,
  output logic signed [OUT_W-1:0] q_o,
  output logic                    clip_o
);
  import sfir_pkg::*;

  localparam int SH_W = IN_W + 1 - FRAC_BITS;
  localparam logic signed [SH_W-1:0] HI = {{(SH_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SH_W-1:0] LO = ~HI;

  logic signed [IN_W:0]   x;
  logic signed [SH_W-1:0] s;

  assign x = {acc_i[IN_W-1], acc_i} + (IN_W+1)'(ROUND_ADD);
  assign s = x[IN_W:FRAC_BITS];

  always_comb begin
    q_o    = s[OUT_W-1:0];
    clip_o = 1'b0;
    priority if (s > HI) begin
      q_o    = HI[OUT_W-1:0];
      clip_o = 1'b1;
    end else if (s < LO) begin
      q_o    = LO[OUT_W-1:0];
      clip_o = 1'b1;
    end
  end

endmodule

// ----- sv/sfir_hcell.sv -----
// sfir_hcell: one horizontal window cell, holds a sample, passes it on
// and forms its registered coefficient product; depends on sfir_pkg
module sfir_hcell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          shift_i,
  input  logic                                          mul_en_i,
  input  logic signed [SAMPLE_BITS-1:0]                 din_i,
  input  logic signed [sfir_pkg::COEF_W-1:0]            coef_i,
  output logic signed [SAMPLE_BITS-1:0]                 dout_o,
  output logic signed [SAMPLE_BITS+sfir_pkg::COEF_W-1:0] prod_o
);
  import sfir_pkg::*;

  logic signed [SAMPLE_BITS-1:0]        sample_q;
  logic signed [SAMPLE_BITS+COEF_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= din_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= coef_i * sample_q;
    end
  end

  assign dout_o = sample_q;
  assign prod_o = prod_q;

endmodule

// ----- sv/sfir_vbank.sv -----
// sfir_vbank: one line store of the ring with its vertical tap product
// depends on sfir_pkg
module sfir_vbank #(
  parameter int MID_W = 20,
  parameter int AW    = 10
) (
  input  logic                                    clk_i,
  input  logic                                    adv_i,
  input  logic                                    wr_en_i,
  input  logic [AW-1:0]                           addr_i,
  input  logic [MID_W:0]                          wdata_i,
  input  logic                                    own_i,
  input  logic signed [MID_W-1:0]                 fwd_h_i,
  input  logic                                    fwd_clip_i,
  input  logic                                    use_i,
  input  logic signed [sfir_pkg::COEF_W-1:0]      coef_i,
  output logic signed [MID_W+sfir_pkg::COEF_W-1:0] prod_o,
  output logic                                    clip_o
);
  import sfir_pkg::*;

  logic [MID_W:0]                  mem [2**AW];
  logic [MID_W:0]                  rd_q;
  logic signed [MID_W-1:0]         sel;
  logic signed [MID_W+COEF_W-1:0]  prod_q;
  logic                            clip_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (wr_en_i) begin
        mem[addr_i] <= wdata_i;
      end
      rd_q <= mem[addr_i];
    end
  end

  assign sel = own_i ? fwd_h_i : $signed(rd_q[MID_W-1:0]);

  // unused rows contribute nothing, even where the store was never written
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (use_i) begin
        prod_q <= coef_i * sel;
      end else begin
        prod_q <= '0;
      end
      clip_q <= use_i && (own_i ? fwd_clip_i : rd_q[MID_W]);
    end
  end

  assign prod_o = prod_q;
  assign clip_o = clip_q;

endmodule

// ----- sv/separable_2d_fir_filter.sv -----
// Separable 2-D FIR filter (valid-region correlation), one pixel word per
// clock. A row of eight window cells feeds a registered horizontal sum; the
// rounded row value goes into a ring of eight line stores, one per row, each
// read at the current column, and a vertical sum over the newest tap_count_y
// rows gives the result; the pipeline holds while the result word waits.
// Depends on sfir_pkg, sfir_pixel_if, sfir_result_if and the sfir_*
// cell modules.
module separable_2d_fir_filter #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sfir_pixel_if.sink                          pix_i,
  sfir_result_if.source                       res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sfir_pkg::ADDR_W-1:0]         paddr,
  input  logic [sfir_pkg::DATA_W-1:0]         pwdata,
  output logic [sfir_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import sfir_pkg::*;

  localparam int MID_W = SAMPLE_BITS + 4;
  localparam int OUT_W = SAMPLE_BITS + 8;
  localparam int HP_W  = SAMPLE_BITS + COEF_W;
  localparam int HS_W  = HP_W + TAP_W;
  localparam int VP_W  = MID_W + COEF_W;
  localparam int VS_W  = VP_W + TAP_W;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_WIDTH + MAX_TAPS);

  typedef struct packed {
    logic             v;
    logic             emit;
    logic             last;
    logic [TAP_W-1:0] slot;
    logic [AW-1:0]    addr;
  } ctrl_t;

  cfg_t cfg;

  sfir_apb_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  logic adv, accept;
  assign adv         = !res_o.valid || res_o.ready;
  assign accept      = pix_i.valid && adv;
  assign pix_i.ready = adv;

  // position tracking
  logic [CW-1:0]    col_q, p, txm1, ow, rel;
  logic [CNT_W-1:0] rows_q, rs_raw, rs, tx, ty;
  logic [TAP_W-1:0] ring_q, slot;
  logic             hv, emit, last, row_end;
  ctrl_t            c0_d, c0_q, c1_q, c2_q, c3_q, c4_q, c5_q;

  assign tx   = clamp_taps(cfg.tap_count_x);
  assign ty   = clamp_taps(cfg.tap_count_y);
  assign txm1 = CW'(tx) - CW'(1);

  always_comb begin
    if (cfg.out_width == '0) ow = CW'(1);
    else if (32'(cfg.out_width) > 32'(MAX_WIDTH)) ow = CW'(MAX_WIDTH);
    else ow = CW'(cfg.out_width);
  end

  assign p       = pix_i.frame_start ? '0 : col_q;
  assign rs_raw  = pix_i.frame_start ? '0 : rows_q;
  assign rs      = (rs_raw > ty) ? ty : rs_raw;
  assign slot    = pix_i.frame_start ? '0 : ring_q;
  assign rel     = p - txm1;
  assign hv      = (p >= txm1) && (rel < ow);
  assign last    = rel == (ow - CW'(1));
  assign emit    = hv && ({1'b0, rs} + 5'd1 >= {1'b0, ty});
  assign row_end = p >= (ow + txm1 - CW'(1));

  assign c0_d = '{v: accept && hv, emit: accept && emit, last: last,
                  slot: slot, addr: rel[AW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      rows_q <= '0;
      ring_q <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_q  <= '0;
        ring_q <= slot + TAP_W'(1);
        rows_q <= (rs < ty) ? rs + CNT_W'(1) : rs;
      end else begin
        col_q  <= p + CW'(1);
        ring_q <= slot;
        rows_q <= rs;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
    end else if (adv) begin
      c0_q <= c0_d;
      c1_q <= c0_q;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
      c5_q <= c4_q;
    end
  end

  // horizontal window chain
  logic signed [SAMPLE_BITS-1:0] win  [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] din  [MAX_TAPS];
  logic signed [COEF_W-1:0]      hcoef[MAX_TAPS];
  logic signed [HP_W-1:0]        hprod[MAX_TAPS];

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_hcell
    if (j == 0) begin : g_head
      assign din[j] = pix_i.pixel;
    end else begin : g_link
      assign din[j] = pix_i.frame_start ? '0 : win[j-1];
    end
    assign hcoef[j] = (CNT_W'(j) < tx)
                    ? coef_sel(cfg.row_taps_low, cfg.row_taps_high,
                               TAP_W'(tx - CNT_W'(1) - CNT_W'(j)))
                    : '0;
    sfir_hcell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk_i, .rst_ni, .shift_i(accept), .mul_en_i(adv),
      .din_i(din[j]), .coef_i(hcoef[j]), .dout_o(win[j]), .prod_o(hprod[j])
    );
  end

  logic signed [HS_W-1:0]  hsum_d, hsum_q;
  logic signed [MID_W-1:0] hq, h3_q;
  logic                    hclip, hclip3_q;

  always_comb begin
    hsum_d = '0;
    for (int j = 0; j < MAX_TAPS; j++) begin
      hsum_d = hsum_d + HS_W'(hprod[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hsum_q   <= hsum_d;
      h3_q     <= hq;
      hclip3_q <= hclip;
    end
  end

  sfir_round_sat #(.IN_W(HS_W), .OUT_W(MID_W)) u_hsat (
    .acc_i(hsum_q), .q_o(hq), .clip_o(hclip)
  );

  // ring of line stores
  logic signed [VP_W-1:0] vprod[MAX_TAPS];
  logic                   vclip[MAX_TAPS];

  for (genvar b = 0; b < MAX_TAPS; b++) begin : g_bank
    logic [TAP_W-1:0]     k;
    logic                 use_b;
    logic signed [COEF_W-1:0] vc;
    assign k     = TAP_W'(b) - c3_q.slot + TAP_W'(ty - CNT_W'(1));
    assign use_b = {1'b0, k} < ty;
    assign vc    = use_b ? coef_sel(cfg.col_taps_low, cfg.col_taps_high, k) : '0;
    sfir_vbank #(.MID_W(MID_W), .AW(AW)) u_bank (
      .clk_i, .adv_i(adv),
      .wr_en_i(c2_q.v && (c2_q.slot == TAP_W'(b))),
      .addr_i(c2_q.addr), .wdata_i({hclip, hq}),
      .own_i(c3_q.slot == TAP_W'(b)), .fwd_h_i(h3_q), .fwd_clip_i(hclip3_q),
      .use_i(use_b), .coef_i(vc), .prod_o(vprod[b]), .clip_o(vclip[b])
    );
  end

  logic signed [VS_W-1:0]  vsum_d, vsum_q;
  logic                    vany_d, vany_q;
  logic signed [OUT_W-1:0] vq;
  logic                    vsat;

  always_comb begin
    vsum_d = '0;
    vany_d = 1'b0;
    for (int b = 0; b < MAX_TAPS; b++) begin
      vsum_d = vsum_d + VS_W'(vprod[b]);
      vany_d = vany_d | vclip[b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vsum_q <= vsum_d;
      vany_q <= vany_d;
    end
  end

  sfir_round_sat #(.IN_W(VS_W), .OUT_W(OUT_W)) u_vsat (
    .acc_i(vsum_q), .q_o(vq), .clip_o(vsat)
  );

  // result word register
  logic                    out_v_q;
  logic signed [OUT_W-1:0] out_val_q;
  logic                    out_last_q, out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= c5_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_val_q  <= vq;
      out_last_q <= c5_q.last;
      out_sat_q  <= vsat || vany_q;
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.value       = out_val_q;
  assign res_o.last_in_row = out_last_q;
  assign res_o.saturated   = out_sat_q;

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> ($stable(c5_q) && $stable(c0_q)))
    else $error("pipeline moved while result word stalled");

  a_rows_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_q <= CNT_W'(MAX_TAPS))
    else $error("row count beyond tap limit");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c0_q.emit |-> c0_q.v) and (c5_q.emit |-> c5_q.v))
    else $error("result issued without row value");

  a_no_pix_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> $stable(col_q))
    else $error("column moved while stalled");

endmodule

// ----- tb/sfir_tb_if.sv -----
// sfir_tb_if: thin wrappers are not needed; this file holds the testbench
// scoreboard class for the separable fir filter; depends on sfir_pkg
package sfir_tb_pkg;
  import sfir_pkg::*;

  typedef struct packed {
    logic signed [23:0] value;
    logic               last_in_row;
    logic               saturated;
  } fir_word_t;

  class fir_scoreboard;
    logic [CNT_W-1:0] tap_x, tap_y;
    logic [63:0]      row_lo, row_hi, col_lo, col_hi;
    logic [OWR_W-1:0] width;
    longint           window[MAX_TAPS];
    longint           lines[MAX_TAPS][1024];
    bit               clips[MAX_TAPS][1024];
    int               col_pos, rows_seen, ring;
    fir_word_t        pending[$];
    int               errors;

    function new();
      tap_x = 1; tap_y = 1; row_lo = 64'd16384; row_hi = 0;
      col_lo = 64'd16384; col_hi = 0; width = 11'd1024;
      foreach (window[k]) window[k] = 0;
      col_pos = 0; rows_seen = 0; ring = 0; errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [63:0] v);
      case (idx)
        REG_TAP_X:  tap_x = v[3:0];
        REG_TAP_Y:  tap_y = v[3:0];
        REG_ROW_LO: row_lo = v;
        REG_ROW_HI: row_hi = v;
        REG_COL_LO: col_lo = v;
        REG_COL_HI: col_hi = v;
        REG_OUT_W:  width = v[10:0];
        default: ;
      endcase
    endfunction

    function longint tap_of(logic [63:0] lo, logic [63:0] hi, int k);
      logic [63:0] w;
      logic signed [15:0] c;
      w = (k < 4) ? lo : hi;
      c = w[(k % 4)*16 +: 16];
      return longint'(c);
    endfunction

    function longint round_sat(longint acc, int bits, ref bit clip);
      longint q, hi;
      q = (acc + 8192) >>> 14;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (q > hi) begin clip = 1; return hi; end
      if (q < -hi - 1) begin clip = 1; return -hi - 1; end
      return q;
    endfunction

    function void note_pixel(logic signed [15:0] pixel, bit frame_start);
      int tx, ty, ow, o, slot, r;
      longint acc, h, v;
      bit hclip, vclip, anyclip;
      fir_word_t w;
      tx = (tap_x == 0) ? 1 : (tap_x > 8 ? 8 : tap_x);
      ty = (tap_y == 0) ? 1 : (tap_y > 8 ? 8 : tap_y);
      ow = (width == 0) ? 1 : (width > 1024 ? 1024 : width);
      if (frame_start) begin
        col_pos = 0; rows_seen = 0; ring = 0;
        foreach (window[k]) window[k] = 0;
      end
      if (rows_seen > ty) rows_seen = ty;
      for (int k = MAX_TAPS - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = pixel;
      if (col_pos >= tx - 1 && col_pos - (tx - 1) < ow) begin
        o = col_pos - (tx - 1);
        slot = ring;
        acc = 0; hclip = 0; vclip = 0; anyclip = 0;
        for (int k = 0; k < tx; k++) acc += tap_of(row_lo, row_hi, k) * window[tx-1-k];
        h = round_sat(acc, 20, hclip);
        lines[slot][o] = h;
        clips[slot][o] = hclip;
        if (rows_seen + 1 >= ty) begin
          acc = 0;
          for (int k = 0; k < ty; k++) begin
            r = (slot + 16 - (ty - 1) + k) % MAX_TAPS;
            acc += tap_of(col_lo, col_hi, k) * lines[r][o];
            if (clips[r][o]) anyclip = 1;
          end
          v = round_sat(acc, 24, vclip);
          w.value = v[23:0];
          w.last_in_row = (o == ow - 1);
          w.saturated = vclip | anyclip;
          pending.push_back(w);
        end
      end
      if (col_pos >= ow + tx - 2) begin
        col_pos = 0;
        ring = (ring + 1) % MAX_TAPS;
        if (rows_seen < ty) rows_seen++;
      end else begin
        col_pos++;
      end
    endfunction

    function void check_word(fir_word_t got);
      fir_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        $display("%0t: mismatch expected %p actual %p", $time, exp_w, got);
        errors++;
      end
    endfunction
  endclass
endpackage

// ----- tb/separable_2d_fir_filter_tb.sv -----
// separable_2d_fir_filter_tb: drives pixel frames under several filter
// settings and checks each result word against a scoreboard model
// depends on sfir_pkg, sfir_tb_pkg, the channel interfaces and the rtl
module separable_2d_fir_filter_tb;
  import sfir_pkg::*;
  import sfir_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = 0;
  logic [DATA_W-1:0] pwdata = 0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  sfir_pixel_if  pix();
  sfir_result_if res();

  separable_2d_fir_filter dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .pix_i(pix.sink), .res_o(res.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  fir_scoreboard board = new();
  int idle_count = 0;
  int hold_cycles = 0;
  bit timed_out = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    pix.valid = 0; pix.pixel = 0; pix.frame_start = 0; res.ready = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix.valid && pix.ready) board.note_pixel(pix.pixel, pix.frame_start);
      if (res.valid && res.ready)
        board.check_word({res.value, res.last_in_row, res.saturated});
      if ((pix.valid && pix.ready) || (res.valid && res.ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
    end
  end

  // result side ready with random stalls and a long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        res.ready <= 0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 1)) gap = 0;
      if (gap > 0) begin
        res.ready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      res.ready <= 1;
      @(posedge clk_i);
      while (!(res.valid && res.ready)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (idle_count > 20000 && !timed_out) begin
      timed_out = 1;
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(8 * idx); pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_reg(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_pixel(logic signed [15:0] p, bit fs, bit busy);
    int gap;
    gap = busy ? 0 : $urandom_range(0, 11);
    if (!busy && $urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      pix.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1; pix.pixel <= p; pix.frame_start <= fs;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    pix.valid <= 0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_taps(int mode);
    logic [63:0] w;
    for (int k = 0; k < 4; k++) begin
      case (mode)
        0: w[k*16 +: 16] = $urandom_range(0, 65535);
        1: w[k*16 +: 16] = 16'h7fff;
        2: w[k*16 +: 16] = 16'h8000;
        default: w[k*16 +: 16] = 16'($signed($urandom_range(0, 8192)) - 4096);
      endcase
    end
    return w;
  endfunction

  function automatic logic signed [15:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic run_frame(int rows, int ow, int tx, bit busy);
    int len;
    len = ow + tx - 1;
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < len; c++)
        send_pixel(rand_pixel(), (r == 0 && c == 0), busy);
  endtask

  initial begin
    int tx, ty, ow, rows, sent;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: tiny widths and reset coefficients, then extremes
    write_reg(REG_OUT_W, 11'd3);
    send_pixel(16'sh7fff, 1, 0);
    send_pixel(16'sh8000, 0, 0);
    send_pixel(16'sh0000, 0, 0);
    send_pixel(16'sh0001, 1, 0);
    send_pixel(-16'sh0001, 0, 0);
    drain();
    write_reg(REG_TAP_X, 4'd0);
    write_reg(REG_TAP_Y, 4'd15);
    write_reg(REG_ROW_LO, rand_taps(1));
    write_reg(REG_ROW_HI, rand_taps(1));
    write_reg(REG_COL_LO, rand_taps(1));
    write_reg(REG_COL_HI, rand_taps(2));
    write_reg(REG_OUT_W, 11'd0);
    run_frame(9, 1, 1, 0);
    drain();
    write_reg(REG_TAP_X, 4'd9);
    write_reg(REG_TAP_Y, 4'd0);
    write_reg(REG_OUT_W, 11'd2);
    run_frame(2, 2, 8, 0);
    drain();

    // random phases
    sent = 0;
    while (sent < 700) begin
      tx = $urandom_range(1, 8);
      ty = $urandom_range(1, 8);
      ow = (sent > 0 && sent < 200 && $urandom_range(0, 9) == 0)
         ? 1024 : $urandom_range(1, 6);
      rows = ty + $urandom_range(0, 3);
      if (ow == 1024) rows = 1;
      write_reg(REG_TAP_X, tx);
      write_reg(REG_TAP_Y, ty);
      write_reg(REG_ROW_LO, rand_taps($urandom_range(0, 3)));
      write_reg(REG_ROW_HI, rand_taps($urandom_range(0, 3)));
      write_reg(REG_COL_LO, rand_taps($urandom_range(0, 3)));
      write_reg(REG_COL_HI, rand_taps($urandom_range(0, 3)));
      write_reg(REG_OUT_W, ow);
      if (sent == 0) hold_cycles = 200;
      run_frame(rows, ow, tx, sent == 0);
      sent += rows * (ow + tx - 1);
      drain();
    end

    if (board.pending.size() == 0 && board.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
